// ===== hw/rtl/substring_first_match_search_core_macros.svh =====
// Assertion helpers for the substring search core.
`ifndef SUBSTRING_FIRST_MATCH_SEARCH_CORE_MACROS_SVH
`define SUBSTRING_FIRST_MATCH_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, off while in reset.
`define SFMS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sfms: same-cycle check failed");

// Next-cycle implication, off while in reset.
`define SFMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sfms: next-cycle check failed");

`endif

// ===== hw/rtl/sfms_pkg.sv =====
`default_nettype none

package sfms_pkg;

  localparam int unsigned HAY_W      = 8;
  localparam int unsigned POS_OUT_W  = 32;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned NEEDLE_WORDS = 4;
  localparam int unsigned NEEDLE_SLOTS = 32;   // bytes held by the four needle words
  localparam int unsigned SLOT_W       = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEEDLE_LEN = 3'd0,
    CFG_NEEDLE_W0  = 3'd1,
    CFG_NEEDLE_W1  = 3'd2,
    CFG_NEEDLE_W2  = 3'd3,
    CFG_NEEDLE_W3  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic                 found;
    logic [POS_OUT_W-1:0] position;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sfms_if.sv =====
`default_nettype none

// Haystack byte channel.
interface sfms_in_if import sfms_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HAY_W-1:0] hay_byte;
  logic             last_byte;

  modport source (output valid, hay_byte, last_byte, input ready);
  modport sink   (input valid, hay_byte, last_byte, output ready);
endinterface

// Result channel.
interface sfms_out_if import sfms_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [POS_OUT_W-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/substring_first_match_search_core.sv =====
// Result path: a result is registered at the edge that takes the deciding byte and is
//   offered in the following cycle, or waits in the skid slot behind a held result.
// Throughput: one haystack byte per cycle; the full window compare is one pass.
//   Input ready drops only while both the result register and its skid slot are full.
// Reset: needle registers, byte counter, done flag and result slots clear at once;
//   the byte window is not cleared and needs no clearing pass.
`default_nettype none

`include "substring_first_match_search_core_macros.svh"

module substring_first_match_search_core
  import sfms_pkg::*;
#(
  parameter int unsigned NEEDLE_MAX = 32,  // 2..32 window bytes
  parameter int unsigned POS_WIDTH  = 32   // 8..48 byte counter bits
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // configuration write port
  input  wire                   cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [CFG_DATA_W-1:0] cfg_data_i,
  // haystack beats in, results out
  sfms_in_if.sink               in_i,
  sfms_out_if.source            out_o
);

  // --------------------------------------------------------------------------
  // Needle configuration
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]                        needle_len_q;
  logic [NEEDLE_WORDS-1:0][CFG_DATA_W-1:0] needle_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_len_q <= '0;
      needle_w_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_NEEDLE_LEN: needle_len_q  <= cfg_data_i[LEN_W-1:0];
        CFG_NEEDLE_W0:  needle_w_q[0] <= cfg_data_i;
        CFG_NEEDLE_W1:  needle_w_q[1] <= cfg_data_i;
        CFG_NEEDLE_W2:  needle_w_q[2] <= cfg_data_i;
        CFG_NEEDLE_W3:  needle_w_q[3] <= cfg_data_i;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // byte k of the needle, little-endian inside each word
  logic [NEEDLE_SLOTS-1:0][HAY_W-1:0] needle_bytes;
  assign needle_bytes = needle_w_q;

  // lengths past the window depth clamp to the window depth
  localparam logic [LEN_W-1:0] LenMax = LEN_W'(NEEDLE_MAX);
  logic [LEN_W-1:0] len_eff;
  assign len_eff = (needle_len_q > LenMax) ? LenMax : needle_len_q;

  // --------------------------------------------------------------------------
  // Haystack state
  // --------------------------------------------------------------------------
  logic [NEEDLE_MAX-1:0][HAY_W-1:0] win_q, win_d;   // entry 0 = newest byte
  logic [POS_WIDTH-1:0]             cnt_q, cnt_d;
  logic                             given_q, given_d;

  logic                 in_acc;
  logic [POS_WIDTH-1:0] cnt_inc;
  logic [NEEDLE_MAX-1:0] lane_ok;
  logic                 len_zero;
  logic                 long_enough;
  logic                 hit;
  logic                 emit;
  logic                 push;
  result_t              res_new;

  assign in_acc = in_i.valid && in_i.ready;

  // window after shifting in the current beat
  logic [NEEDLE_MAX-1:0][HAY_W-1:0] win_shift;
  assign win_shift = {win_q[NEEDLE_MAX-2:0], in_i.hay_byte};

  // saturating byte count including this beat
  assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + POS_WIDTH'(1);

  // Window entry j lines up with needle byte len-1-j; lanes past len always pass.
  always_comb begin
    for (int j = 0; j < NEEDLE_MAX; j++) begin
      logic [LEN_W-1:0] nidx;
      nidx = len_eff - LEN_W'(j) - LEN_W'(1);
      if (LEN_W'(j) < len_eff) begin
        lane_ok[j] = (win_shift[j] == needle_bytes[nidx[SLOT_W-1:0]]);
      end else begin
        lane_ok[j] = 1'b1;
      end
    end
  end

  assign len_zero    = (len_eff == '0);
  assign long_enough = (cnt_inc >= POS_WIDTH'(len_eff));
  assign hit         = len_zero || (long_enough && (&lane_ok));
  assign emit        = !given_q && (hit || in_i.last_byte);
  assign push        = in_acc && emit;

  // empty needle reports position zero; a miss reports zero as well
  assign res_new.found    = hit;
  assign res_new.position = (hit && !len_zero) ?
                            POS_OUT_W'(cnt_inc - POS_WIDTH'(len_eff)) : '0;

  // After a result, beats are swallowed until the last one, which restarts
  // without shifting the window.
  always_comb begin
    win_d   = win_q;
    cnt_d   = cnt_q;
    given_d = given_q;
    if (in_acc) begin
      if (!given_q) begin
        win_d = win_shift;
        cnt_d = cnt_inc;
      end
      if (in_i.last_byte) begin
        cnt_d   = '0;
        given_d = 1'b0;
      end else if (emit) begin
        given_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      given_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      given_q <= given_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register with skid slot
  // --------------------------------------------------------------------------
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop        = out_valid_q && out_o.ready;
  // a free skid slot always has room for this beat's result
  assign in_i.ready = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push;
        out_d       = res_new;
      end
    end else if (push) begin
      if (!out_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = res_new;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = res_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.found    = out_q.found;
  assign out_o.position = out_q.position;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic live_beat;   // beat taken while a result is still owed
  logic idle_beat;   // non-last beat taken after the result went out
  assign live_beat = in_acc && !given_q;
  assign idle_beat = in_acc && given_q && !in_i.last_byte;

  // skid only fills behind a held result
  `SFMS_ASSERT_IMPL(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  // once done, non-last beats leave the counter and done flag alone
  `SFMS_ASSERT_NEXT(a_hold_after_result, clk_i, rst_ni, idle_beat, given_q && $stable(cnt_q))
  // an empty needle answers on the first live beat
  `SFMS_ASSERT_NEXT(a_empty_needle_answers, clk_i, rst_ni, live_beat && len_zero, out_valid_q)

endmodule

`default_nettype wire

// ===== dv/sfms_first_match_checker.sv =====
// Watches the config port and both channels, predicts the first-match result
// for every haystack, and compares each result beat in order.
module sfms_first_match_checker
  import sfms_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  hay_valid_i,
  input  logic                  hay_ready_i,
  input  logic [HAY_W-1:0]      hay_byte_i,
  input  logic                  last_byte_i,
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  logic                  found_i,
  input  logic [POS_OUT_W-1:0]  position_i,
  output int unsigned           mismatch_cnt_o,
  output int unsigned           pending_o,
  output int unsigned           results_o,
  output int unsigned           matches_o
);

  logic [LEN_W-1:0]      ndl_len;
  logic [CFG_DATA_W-1:0] ndl_word [NEEDLE_WORDS];
  logic [HAY_W-1:0]      recent [NEEDLE_SLOTS];  // entry 0 = newest byte
  logic [POS_OUT_W-1:0]  seen_cnt;
  logic                  answered;

  result_t     expected_results [$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned matches_seen;

  assign mismatch_cnt_o = mismatches;
  assign results_o      = results_seen;
  assign matches_o      = matches_seen;

  task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (cfg_reg_e'(idx))
      CFG_NEEDLE_LEN: ndl_len = data[LEN_W-1:0];
      CFG_NEEDLE_W0:  ndl_word[0] = data;
      CFG_NEEDLE_W1:  ndl_word[1] = data;
      CFG_NEEDLE_W2:  ndl_word[2] = data;
      CFG_NEEDLE_W3:  ndl_word[3] = data;
      default: ;
    endcase
  endtask

  // Per byte: if not yet answered, shift the window, bump the count, compare the newest bytes.
  task automatic scan_byte(input logic [HAY_W-1:0] b, input logic lst);
    int unsigned n;
    int k;
    logic hit;
    result_t r;
    if (answered) begin
      // done for this haystack; only the last byte matters (restart)
      if (lst) begin
        seen_cnt = '0;
        answered = 1'b0;
      end
      return;
    end
    n = (ndl_len > NEEDLE_SLOTS) ? NEEDLE_SLOTS : ndl_len;
    for (k = NEEDLE_SLOTS - 1; k > 0; k--) recent[k] = recent[k-1];
    recent[0] = b;
    if (seen_cnt != '1) seen_cnt = seen_cnt + 1'b1;
    if (n == 0) begin
      hit = 1'b1;
    end else begin
      hit = (seen_cnt >= n);
      for (k = 0; k < int'(n); k++)
        if (recent[n-1-k] != ndl_word[k/8][(k%8)*8 +: 8]) hit = 1'b0;
    end
    if (!hit && !lst) return;
    r.found    = hit;
    // empty needle and misses both report position zero
    r.position = (hit && n != 0) ? seen_cnt - n : '0;
    expected_results.push_back(r);
    if (lst) begin
      seen_cnt = '0;
      answered = 1'b0;
    end else begin
      answered = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t got;
    result_t want;
    if (!rst_ni) begin
      ndl_len  = '0;
      ndl_word = '{default: '0};
      recent   = '{default: '0};
      seen_cnt = '0;
      answered = 1'b0;
      expected_results.delete();
      mismatches   = 0;
      results_seen = 0;
      matches_seen = 0;
      pending_o   <= 0;
    end else begin
      // results first: a beat taken at this edge cannot answer before the next one
      if (res_valid_i && res_ready_i) begin
        got.found    = found_i;
        got.position = position_i;
        results_seen++;
        if (found_i) matches_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          $error("result beat with nothing expected: found %0d, position %0d",
                 got.found, got.position);
        end else begin
          want = expected_results.pop_front();
          if (want.found !== got.found) begin
            mismatches++;
            $error("found: expected %0d, got %0d", want.found, got.found);
          end
          if (want.position !== got.position) begin
            mismatches++;
            $error("position: expected %0d, got %0d", want.position, got.position);
          end
        end
      end
      if (cfg_we_i) apply_cfg(cfg_idx_i, cfg_data_i);
      if (hay_valid_i && hay_ready_i) scan_byte(hay_byte_i, last_byte_i);
      pending_o <= expected_results.size();
    end
  end

endmodule

// ===== dv/substring_first_match_search_core_tb.sv =====
// Stimulus and verdict for the substring search core. A checker sits beside
// the DUT and does all prediction; this module only drives beats, config
// writes and result-side backpressure.
module substring_first_match_search_core_tb;
  import sfms_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_BYTES = 70;   // 10 phases -> ~700 random beats
  localparam int unsigned HOLD_CYCLES = 150;  // long result-side stall
  localparam int unsigned DRAIN_WAIT  = 4;    // margin after the last expected result

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sfms_in_if  in_if ();
  sfms_out_if out_if ();

  // stimulus-side knobs seen by the result sink
  logic no_idle  = 1'b0;
  logic hold_req = 1'b0;

  int unsigned mismatch_cnt, pending, results, match_total;
  int unsigned bytes_sent;
  int unsigned settings_used;
  int unsigned cycles = 0;

  logic [HAY_W-1:0] ndl [NEEDLE_SLOTS];  // needle as loaded into the DUT
  logic [HAY_W-1:0] hay_q [$];           // haystack being built

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  substring_first_match_search_core #(
    .NEEDLE_MAX (32),
    .POS_WIDTH  (32)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  sfms_first_match_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .hay_valid_i    (in_if.valid),
    .hay_ready_i    (in_if.ready),
    .hay_byte_i     (in_if.hay_byte),
    .last_byte_i    (in_if.last_byte),
    .res_valid_i    (out_if.valid),
    .res_ready_i    (out_if.ready),
    .found_i        (out_if.found),
    .position_i     (out_if.position),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending),
    .results_o      (results),
    .matches_o      (match_total)
  );

  // Hard stop in case a result never shows up or the input never frees.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
      $display("substring_first_match_search_core_tb NOT OK");
      $finish;
    end
  end

  // Result sink: random ready, one long hold-off when asked, none in the
  // no-idle phase. The hold is counted here so the sender keeps offering
  // beats and the DUT has to fill its result slots and drop in.ready.
  initial begin : result_sink
    int unsigned hold_left;
    logic        hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= no_idle || ($urandom_range(99) >= 27);
      end
    end
  end

  // All drive tasks are entered right after a rising edge.
  task automatic send_byte(input logic [HAY_W-1:0] b, input logic lst);
    while (!no_idle && $urandom_range(99) < 27) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.hay_byte  <= b;
    in_if.last_byte <= lst;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_haystack();
    int i;
    for (i = 0; i < hay_q.size(); i++) send_byte(hay_q[i], i == hay_q.size() - 1);
  endtask

  // Stop sending, wait for every expected result, then let the pipe go quiet
  // (a last byte that only restarts the block gives nothing to wait on).
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Writes the length word and all four needle words from ndl[].
  task automatic load_needle(input logic [CFG_DATA_W-1:0] len_word);
    cfg_reg_e                word_reg [NEEDLE_WORDS];
    logic [CFG_DATA_W-1:0]   packed_word;
    int w, k;
    word_reg = '{CFG_NEEDLE_W0, CFG_NEEDLE_W1, CFG_NEEDLE_W2, CFG_NEEDLE_W3};
    write_reg(CFG_NEEDLE_LEN, len_word);
    for (w = 0; w < NEEDLE_WORDS; w++) begin
      for (k = 0; k < 8; k++) packed_word[k*8 +: 8] = ndl[w*8 + k];
      write_reg(word_reg[w], packed_word);
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Either any byte value, or a two-letter alphabet around alpha so that
  // partial matches and overlapping restarts show up often.
  function automatic logic [HAY_W-1:0] pick_byte(input bit full, input logic [HAY_W-1:0] alpha);
    return full ? HAY_W'($urandom_range(255)) : alpha ^ HAY_W'($urandom_range(1));
  endfunction

  // Random haystack; most carry the needle (sometimes with one byte broken),
  // some are shorter than the needle.
  task automatic build_haystack(input int unsigned n, input bit full,
                                input logic [HAY_W-1:0] alpha);
    int unsigned hay_len, ofs, k;
    hay_q.delete();
    if (n == 0) hay_len = $urandom_range(1, 6);
    else if (n > 1 && $urandom_range(99) < 15) hay_len = $urandom_range(1, n - 1);
    else hay_len = $urandom_range(1, n + 12);
    for (k = 0; k < hay_len; k++) hay_q.push_back(pick_byte(full, alpha));
    if (n != 0 && hay_len >= n && $urandom_range(99) < 70) begin
      ofs = $urandom_range(0, hay_len - n);
      for (k = 0; k < n; k++) hay_q[ofs + k] = ndl[k];
      if ($urandom_range(99) < 25) begin
        k = ofs + $urandom_range(0, n - 1);
        hay_q[k] = hay_q[k] ^ 8'h01;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned p, k, len_raw, n, phase_bytes;
    bit                    full;
    logic [HAY_W-1:0]      alpha;
    logic [CFG_DATA_W-1:0] len_word;

    bytes_sent      = 0;
    settings_used   = 1;  // reset default: empty needle
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_NEEDLE_LEN;
    cfg_data_i      = '0;
    in_if.valid     = 1'b0;
    in_if.hay_byte  = '0;
    in_if.last_byte = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // empty needle straight out of reset: hit at 0 on the first byte,
    // including a one-byte haystack; trailing bytes are ignored
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h00, 1'b1);
    drain();

    for (k = 0; k < NEEDLE_SLOTS; k++) ndl[k] = HAY_W'($urandom_range(255));
    ndl[0] = "a";
    ndl[1] = "b";
    ndl[2] = "c";
    load_needle(64'd3);
    // haystack shorter than the needle -> not found
    send_byte("a", 1'b0);
    send_byte("b", 1'b1);
    // hit at 1, then the trailing last byte only restarts
    send_byte("x", 1'b0);
    send_byte("a", 1'b0);
    send_byte("b", 1'b0);
    send_byte("c", 1'b0);
    send_byte("c", 1'b1);
    // hit that completes on the last byte
    send_byte("a", 1'b0);
    send_byte("b", 1'b0);
    send_byte("c", 1'b1);
    // near miss -> not found, position 0
    send_byte("a", 1'b0);
    send_byte("b", 1'b0);
    send_byte("d", 1'b1);
    drain();

    // --- random phases, one needle setting each ---
    for (p = 0; p < PHASES; p++) begin
      full  = 1'b1;
      alpha = '0;
      case (p)
        0: len_raw = 1;
        1: begin  // longest needle, all zero bytes
          len_raw = 32;
          full    = 1'b0;
          alpha   = 8'h00;
        end
        2: begin  // length above the window saturates to 32; all ones
          len_raw = 63;
          full    = 1'b0;
          alpha   = 8'hFF;
        end
        3: len_raw = 0;
        default: begin
          len_raw = $urandom_range(2, 31);
          full    = $urandom_range(1);
          alpha   = HAY_W'($urandom_range(255));
        end
      endcase
      for (k = 0; k < NEEDLE_SLOTS; k++)
        ndl[k] = (p == 1 || p == 2) ? alpha : pick_byte(full, alpha);
      // junk above the length field must be dropped
      len_word         = (p == 1) ? '0 : {$urandom, $urandom};
      len_word[LEN_W-1:0] = LEN_W'(len_raw);
      load_needle(len_word);

      n = (len_raw > NEEDLE_SLOTS) ? NEEDLE_SLOTS : len_raw;
      no_idle <= (p == 5);
      if (p == 3) hold_req <= 1'b1;  // empty needle: one result per haystack

      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        build_haystack(n, full, alpha);
        phase_bytes += hay_q.size();
        send_haystack();
      end
      drain();
    end

    $display("%0d haystack beats over %0d needle settings, lengths 0 to 32 plus a saturated one",
             bytes_sent, settings_used);
    $display("%0d results checked, %0d of them matches; one %0d-cycle result stall",
             results, match_total, HOLD_CYCLES);
    if (mismatch_cnt == 0) begin
      $display("substring_first_match_search_core_tb OK");
    end else begin
      $display("substring_first_match_search_core_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/sfms_pkg.sv
hw/rtl/sfms_if.sv
hw/rtl/substring_first_match_search_core.sv
dv/sfms_first_match_checker.sv
dv/substring_first_match_search_core_tb.sv
